// ===== rtl/ct3r_pkg.sv =====
package ct3r_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PIX_W   = 8;
  localparam int POS_W   = 11;
  localparam int CODE_W  = 8;
  localparam int SIZE_W  = 12;
  localparam int BND_W   = 14;
  localparam int WIN_N   = 3;
  localparam int WIN_CNT = WIN_N * WIN_N;
  localparam int WIN_CTR = WIN_CNT / 2;
  localparam int MIN_SIZE = 3;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam int OUT_ROW_LSB  = 0;
  localparam int OUT_COL_LSB  = OUT_ROW_LSB + POS_W;
  localparam int OUT_CODE_LSB = OUT_COL_LSB + POS_W;
  localparam int USER_REGION  = 0;
  localparam int USER_VALID   = 1;

  localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(480);

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_WIDTH,
    REG_HEIGHT,
    REG_CENTER_COL,
    REG_CENTER_ROW,
    REG_HALF_COLS,
    REG_HALF_ROWS
  } ct3r_reg_t;

  typedef logic [PIX_W-1:0] ct3r_pix_t;

endpackage

// ===== rtl/census_transform_3x3_region.sv =====
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: pixel; tuser: frame_start
// m_axis    out        tdata: out_row, out_col, census_code; tuser: in_region, out_valid
// apb       in         config registers at byte address 4*index, always ready
//
// One transaction per clock is sustained while m_tready is high; a pixel passes the middle
// stage, then the result register. The line buffer memory is read when a pixel is taken
// and written one stage later. A stalled output holds the result register; the middle
// stage takes a pixel while it is empty or the result register is free or being emptied.
// Reset clears config registers, counters, window and valid flags; line buffers keep data.
module census_transform_3x3_region #(
  parameter int MAX_WIDTH  = ct3r_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ct3r_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ct3r_pkg::S_TDATA_W-1:0] s_tdata,  // pixel
  input  logic                           s_tuser,  // frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ct3r_pkg::M_TDATA_W-1:0] m_tdata,  // out_row, out_col, census_code, zeros
  output logic [ct3r_pkg::M_TUSER_W-1:0] m_tuser,  // in_region, out_valid
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ct3r_pkg::APB_AW-1:0]    paddr,
  input  logic [ct3r_pkg::APB_DW-1:0]    pwdata,
  output logic [ct3r_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import ct3r_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [SIZE_W:0] MAXW_EXT = (SIZE_W + 1)'(MAX_WIDTH);
  localparam logic [SIZE_W:0] MAXH_EXT = (SIZE_W + 1)'(MAX_HEIGHT);
  localparam logic [SIZE_W:0] MIN_EXT  = (SIZE_W + 1)'(MIN_SIZE);

  logic              census_enable;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [POS_W-1:0]  center_col;
  logic [POS_W-1:0]  center_row;
  logic [POS_W-1:0]  half_cols;
  logic [POS_W-1:0]  half_rows;

  logic              cfg_write;
  ct3r_reg_t         cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = ct3r_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      census_enable <= 1'b0;
      image_width   <= RST_WIDTH;
      image_height  <= RST_HEIGHT;
      center_col    <= '0;
      center_row    <= '0;
      half_cols     <= '0;
      half_rows     <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_ENABLE:     census_enable <= pwdata[0];
        REG_WIDTH:      image_width   <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:     image_height  <= pwdata[SIZE_W-1:0];
        REG_CENTER_COL: center_col    <= pwdata[POS_W-1:0];
        REG_CENTER_ROW: center_row    <= pwdata[POS_W-1:0];
        REG_HALF_COLS:  half_cols     <= pwdata[POS_W-1:0];
        REG_HALF_ROWS:  half_rows     <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ENABLE:     prdata = APB_DW'(census_enable);
      REG_WIDTH:      prdata = APB_DW'(image_width);
      REG_HEIGHT:     prdata = APB_DW'(image_height);
      REG_CENTER_COL: prdata = APB_DW'(center_col);
      REG_CENTER_ROW: prdata = APB_DW'(center_row);
      REG_HALF_COLS:  prdata = APB_DW'(half_cols);
      REG_HALF_ROWS:  prdata = APB_DW'(half_rows);
      default:        prdata = '0;
    endcase
  end

  // Effective frame size, clamped to the supported range.
  logic [SIZE_W:0] w_ext;
  logic [SIZE_W:0] h_ext;
  logic [CW:0]     w_eff;
  logic [RW:0]     h_eff;

  always_comb begin
    w_ext = {1'b0, image_width};
    h_ext = {1'b0, image_height};
    if (w_ext < MIN_EXT) begin
      w_ext = MIN_EXT;
    end else if (w_ext > MAXW_EXT) begin
      w_ext = MAXW_EXT;
    end
    if (h_ext < MIN_EXT) begin
      h_ext = MIN_EXT;
    end else if (h_ext > MAXH_EXT) begin
      h_ext = MAXH_EXT;
    end
    w_eff = w_ext[CW:0];
    h_eff = h_ext[RW:0];
  end

  // Region bounds: a centre at position p qualifies when lo + 2 <= p + 1 < hi.
  logic [BND_W-1:0] col_lo2;
  logic [BND_W-1:0] col_hi;
  logic [BND_W-1:0] row_lo2;
  logic [BND_W-1:0] row_hi;
  logic [BND_W-1:0] col_lo2_next;
  logic [BND_W-1:0] col_hi_next;
  logic [BND_W-1:0] row_lo2_next;
  logic [BND_W-1:0] row_hi_next;

  always_comb begin
    col_lo2_next = (center_col >= half_cols) ?
                   BND_W'(center_col - half_cols) + BND_W'(2) : BND_W'(2);
    row_lo2_next = (center_row >= half_rows) ?
                   BND_W'(center_row - half_rows) + BND_W'(2) : BND_W'(2);
    col_hi_next  = BND_W'(center_col) + BND_W'(half_cols);
    row_hi_next  = BND_W'(center_row) + BND_W'(half_rows);
    if (col_hi_next > BND_W'(w_eff)) begin
      col_hi_next = BND_W'(w_eff);
    end
    if (row_hi_next > BND_W'(h_eff)) begin
      row_hi_next = BND_W'(h_eff);
    end
  end

  always_ff @(posedge clk) begin
    col_lo2 <= col_lo2_next;
    col_hi  <= col_hi_next;
    row_lo2 <= row_lo2_next;
    row_hi  <= row_hi_next;
  end

  // Input stage: position of the incoming pixel.
  logic          s_accept;
  logic          s1_move;
  logic          out_free;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;

  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    col_cur = s_tuser ? '0 : col_count;
    row_cur = s_tuser ? '0 : row_count;
    if ({1'b0, col_cur} >= w_eff) begin
      col_cur = '0;
    end
    if ({1'b0, row_cur} >= h_eff) begin
      row_cur = '0;
    end
    col_inc = {1'b0, col_cur} + (CW + 1)'(1);
    row_inc = {1'b0, row_cur} + (RW + 1)'(1);
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_count_next = col_inc[CW-1:0];
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (s_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Line buffers: one word per column, upper byte two rows up, lower byte one row up.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_raw;
  logic [2*PIX_W-1:0] s1_line;
  logic [2*PIX_W-1:0] wr_data;

  logic               s1_valid;
  ct3r_pix_t          s1_px;
  logic [CW-1:0]      s1_col;
  logic [RW-1:0]      s1_row;
  logic               s1_fwd;
  logic [2*PIX_W-1:0] s1_fwd_data;

  assign s1_line = s1_fwd ? s1_fwd_data : rd_raw;
  assign wr_data = {s1_line[PIX_W-1:0], s1_px};

  always_ff @(posedge clk) begin
    if (s1_move) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd_raw <= line_mem[col_cur];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // The column still held in the middle stage is written at the same edge, so forward it.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_px       <= s_tdata;
      s1_col      <= col_cur;
      s1_row      <= row_cur;
      s1_fwd      <= s1_valid && (s1_col == col_cur);
      s1_fwd_data <= wr_data;
    end
  end

  // Window and census code.
  ct3r_pix_t        win      [WIN_CNT];
  ct3r_pix_t        win_next [WIN_CNT];
  logic             pos_valid;
  logic             region;
  logic [CODE_W-1:0] code;
  logic [RW-1:0]    row_m1;
  logic [CW-1:0]    col_m1;
  logic [31:0]      row_wide;
  logic [31:0]      col_wide;

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      win_next[i*WIN_N]     = win[i*WIN_N + 1];
      win_next[i*WIN_N + 1] = win[i*WIN_N + 2];
    end
    win_next[2] = s1_line[2*PIX_W-1:PIX_W];
    win_next[5] = s1_line[PIX_W-1:0];
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_CNT; i++) begin
        win[i] <= '0;
      end
    end else if (s1_move) begin
      win <= win_next;
    end
  end

  assign pos_valid = (s1_row != '0) && (s1_col != '0);

  always_comb begin
    region = pos_valid && census_enable &&
             (BND_W'(s1_row) >= row_lo2) && (BND_W'(s1_row) < row_hi) &&
             (BND_W'(s1_col) >= col_lo2) && (BND_W'(s1_col) < col_hi);
    code = '0;
    if (region) begin
      code = {win_next[0] < win_next[WIN_CTR], win_next[1] < win_next[WIN_CTR],
              win_next[2] < win_next[WIN_CTR], win_next[3] < win_next[WIN_CTR],
              win_next[5] < win_next[WIN_CTR], win_next[6] < win_next[WIN_CTR],
              win_next[7] < win_next[WIN_CTR], win_next[8] < win_next[WIN_CTR]};
    end
    row_m1   = s1_row - RW'(1);
    col_m1   = s1_col - CW'(1);
    row_wide = pos_valid ? 32'(row_m1) : '0;
    col_wide = pos_valid ? 32'(col_m1) : '0;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {(M_TDATA_W - OUT_CODE_LSB - CODE_W)'(0), code,
                  col_wide[POS_W-1:0], row_wide[POS_W-1:0]};
      m_tuser <= {pos_valid, region};
    end
  end

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_col) && $stable(s1_row))
    else $error("middle stage lost a stalled transaction");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted transaction did not reach the middle stage");

  a_no_centre: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_VALID] |-> m_tdata == '0 && !m_tuser[USER_REGION])
    else $error("result without a centre carries nonzero fields");

  a_code_outside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_REGION] |-> m_tdata[OUT_CODE_LSB +: CODE_W] == '0)
    else $error("census code set outside the region");

endmodule
